// File: rtl/pes_pkg.sv
// Shared types and constants for the product-except-self block.
package pes_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int VALUE_W     = 16;
    localparam int PROD_W      = 32;
    localparam int IDX_W       = 6;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_BACK,
        ST_PRIME,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;      // input transaction this cycle
        logic close;     // that transaction ends the vector
        logic back;      // backward suffix walk
        logic prime;     // first read of the emit pass
        logic emit_adv;  // output transaction this cycle
    } cmd_t;

    typedef struct packed {
        logic at_full;   // next element fills the store
        logic back_done; // suffix walk writes entry zero
        logic emit_last; // output index is the final one
    } status_t;

endpackage

// File: rtl/pes_ram.sv
// Simple dual-port RAM, one write port and one registered read port.
module pes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/pes_ctrl.sv
// Phase controller: load, backward suffix walk, emit.
module pes_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  pes_pkg::status_t status,
    output pes_pkg::cmd_t    cmd
);
    import pes_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (cmd.close) state_next = ST_BACK;
            end
            ST_BACK: begin
                if (status.back_done) state_next = ST_PRIME;
            end
            ST_PRIME: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (cmd.emit_adv && status.emit_last) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == ST_LOAD);
        m_tvalid     = (state_reg == ST_EMIT);
        cmd.load     = s_tready && s_tvalid;
        cmd.close    = cmd.load && (s_tlast || status.at_full);
        cmd.back     = (state_reg == ST_BACK);
        cmd.prime    = (state_reg == ST_PRIME);
        cmd.emit_adv = m_tvalid && m_tready;
    end

    a_sides_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    a_close_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.close |=> (state_reg == ST_BACK))
        else $error("closing transaction did not start suffix walk");

    a_emit_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_adv && status.emit_last) |=> s_tready)
        else $error("not ready for a new vector after final result");

endmodule

// File: rtl/pes_dp.sv
// Datapath: element and prefix stores, running prefix, suffix walk, emit index.
module pes_dp #(
    parameter int MAX_LEN = pes_pkg::MAX_LEN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pes_pkg::cmd_t                       cmd,
    input  logic signed [pes_pkg::VALUE_W-1:0]  s_value,
    output pes_pkg::status_t                    status,
    output logic [pes_pkg::IDX_W-1:0]           m_index,
    output logic signed [pes_pkg::PROD_W-1:0]   m_product
);
    import pes_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0]      cnt_reg,   cnt_next;
    logic [PROD_W-1:0]  run_reg,   run_next;
    logic [PROD_W-1:0]  suf_reg,   suf_next;
    logic [AW-1:0]      bptr_reg,  bptr_next;
    logic [AW-1:0]      wptr_reg,  wptr_next;
    logic               issue_reg, issue_next;
    logic               rdv_reg,   rdv_next;
    logic [AW-1:0]      eidx_reg,  eidx_next;

    logic [AW-1:0]      pos;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               pre_we;
    logic [PROD_W-1:0]  pre_wdata;
    logic [PROD_W-1:0]  pre_rdata;
    logic [VALUE_W-1:0] elem_rdata;
    logic [PROD_W-1:0]  run_mul;
    logic [PROD_W-1:0]  suf_mul;
    logic [PROD_W-1:0]  res_mul;

    assign pos     = cnt_reg[AW-1:0];
    // low word of the product is the same for signed and unsigned operands
    assign run_mul = run_reg * PROD_W'(s_value);
    assign suf_mul = suf_reg * PROD_W'($signed(elem_rdata));
    assign res_mul = pre_rdata * suf_reg;

    assign status.at_full   = (cnt_reg == CW'(MAX_LEN - 1));
    assign status.back_done = rdv_reg && (wptr_reg == '0);
    assign status.emit_last = ((CW'(eidx_reg) + CW'(1)) == cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            run_reg   <= PROD_W'(1);
            suf_reg   <= PROD_W'(1);
            bptr_reg  <= '0;
            wptr_reg  <= '0;
            issue_reg <= 1'b0;
            rdv_reg   <= 1'b0;
            eidx_reg  <= '0;
        end else begin
            cnt_reg   <= cnt_next;
            run_reg   <= run_next;
            suf_reg   <= suf_next;
            bptr_reg  <= bptr_next;
            wptr_reg  <= wptr_next;
            issue_reg <= issue_next;
            rdv_reg   <= rdv_next;
            eidx_reg  <= eidx_next;
        end
    end

    always_comb begin
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        suf_next   = suf_reg;
        bptr_next  = bptr_reg;
        wptr_next  = wptr_reg;
        issue_next = issue_reg;
        rdv_next   = rdv_reg;
        eidx_next  = eidx_reg;

        if (cmd.load) begin
            cnt_next = cnt_reg + CW'(1);
            run_next = run_mul;
            if (cmd.close) begin
                run_next   = PROD_W'(1);
                suf_next   = PROD_W'(1);
                bptr_next  = pos;
                issue_next = 1'b1;
                rdv_next   = 1'b0;
            end
        end

        // each entry is read, then multiplied and written back in the next cycle
        if (cmd.back) begin
            rdv_next  = issue_reg;
            if (issue_reg) begin
                wptr_next = bptr_reg;
                if (bptr_reg == '0) begin
                    issue_next = 1'b0;
                end else begin
                    bptr_next = bptr_reg - AW'(1);
                end
            end
            if (rdv_reg) begin
                suf_next = suf_mul;
            end
        end

        if (cmd.prime) begin
            eidx_next = '0;
            suf_next  = PROD_W'(1);
        end

        if (cmd.emit_adv) begin
            eidx_next = eidx_reg + AW'(1);
            if (status.emit_last) begin
                cnt_next = '0;
            end
        end
    end

    always_comb begin
        raddr     = cmd.back ? bptr_reg : eidx_next;
        pre_we    = cmd.load || (cmd.back && rdv_reg);
        waddr     = cmd.load ? pos : wptr_reg;
        pre_wdata = cmd.load ? run_reg : res_mul;
    end

    pes_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_elem_ram (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (pos),
        .wdata (s_value),
        .raddr (raddr),
        .rdata (elem_rdata)
    );

    pes_ram #(
        .WIDTH (PROD_W),
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_pre_ram (
        .aclk  (aclk),
        .we    (pre_we),
        .waddr (waddr),
        .wdata (pre_wdata),
        .raddr (raddr),
        .rdata (pre_rdata)
    );

    assign m_index   = IDX_W'(eidx_reg);
    assign m_product = pre_rdata;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_LEN))
        else $error("element count beyond store depth");

    a_walk_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.back && issue_reg && rdv_reg) |-> (wptr_reg != bptr_reg))
        else $error("suffix walk reads the entry it writes");

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_adv |-> (CW'(eidx_reg) < cnt_reg))
        else $error("emit index past vector length");

endmodule

// File: rtl/product_except_self.sv
// Top level: product of all other vector elements, stream in and out.
//
//  channel  | dir | tdata (low bit up)              | tlast
//  ---------+-----+---------------------------------+--------------------
//  s_       | in  | value[15:0]                     | last element
//  m_       | out | index[5:0], product[37:6], pad  | last result
//
// The closing element starts a backward walk over the stores, one entry per cycle,
// then a priming step, then one result per cycle while m_tready is high.
// s_tready is low from the closing element until the final result is taken.
// Synchronous active-low reset returns the block to loading.
module product_except_self #(
    parameter int MAX_LEN = pes_pkg::MAX_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pes_pkg::S_TDATA_W-1:0]     s_tdata,   // value[15:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pes_pkg::M_TDATA_W-1:0]     m_tdata,   // index[5:0], product[37:6]
    output logic                              m_tlast
);
    import pes_pkg::*;

    cmd_t                      cmd;
    status_t                   status;
    logic [IDX_W-1:0]          m_index;
    logic signed [PROD_W-1:0]  m_product;

    pes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pes_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_value   ($signed(s_tdata[VALUE_W-1:0])),
        .status    (status),
        .m_index   (m_index),
        .m_product (m_product)
    );

    assign m_tdata = {{(M_TDATA_W - IDX_W - PROD_W){1'b0}}, m_product, m_index};
    assign m_tlast = status.emit_last;

endmodule
